>>> rtl/rcpsl_pkg.sv
// Shared types, constants and helper functions for the RC pulse servo lag unit.
// Used by the controller, the datapath, the divider and the top level.
package rcpsl_pkg;

  localparam int PW = 46;
  localparam int MW = 45;
  localparam int DW = 20;

  typedef enum logic [1:0] {OP_DEFL, OP_MAP, OP_STEP, OP_LIM} op_t;

  typedef struct packed {
    logic latch;
    logic decide;
    logic mul_go;
    logic div_go;
    logic commit;
    logic load_out;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic fresh;
    logic out_range;
    logic div_done;
  } sts_t;

  localparam logic [1:0]         THR_CH        = 2'd2;
  localparam logic [1:0]         FS_LIVE       = 2'd0;
  localparam logic [1:0]         FS_HOLD       = 2'd1;
  localparam logic [1:0]         FS_ZERO       = 2'd2;
  localparam logic [31:0]        FS_HOLD_US    = 32'd100000;
  localparam logic [31:0]        FS_ZERO_US    = 32'd600000;
  localparam logic [DW-1:0]      TAU_SURF_US   = 20'd60000;
  localparam logic [DW-1:0]      TAU_THR_US    = 20'd300000;
  localparam logic [DW-1:0]      THR_DEFL_DIV  = 20'd10000;
  localparam logic [DW-1:0]      SURF_DEFL_DIV = 20'd65536;
  localparam logic [DW-1:0]      LIM_DIV       = 20'd1000000;
  localparam logic signed [20:0] RATE_SURF_Q16 = 21'sd343147;
  localparam logic signed [20:0] RATE_THR_Q16  = 21'sd196608;
  localparam logic signed [20:0] CDEG_RAD_Q32  = 21'sd749613;
  localparam logic signed [20:0] THR_DEFL_MUL  = 21'sd65536;
  localparam logic [15:0]        CAL_LO_RST    = 16'd1000;
  localparam logic [15:0]        CAL_MID_RST   = 16'd1500;
  localparam logic [15:0]        CAL_HI_RST    = 16'd2000;
  localparam logic [1:0]         NUM_REGS_M1   = 2'd3;

  function automatic logic [15:0] defl_reset(input int i);
    logic [15:0] d;
    unique case (i)
      0:       d = 16'd2000;
      1:       d = 16'd2500;
      2:       d = 16'd10000;
      default: d = 16'd2500;
    endcase
    return d;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [PW-1:0] v);
    logic signed [23:0] r;
    if (v > 46'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -46'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/rcpsl_div.sv
// Sequential signed divider with rounding to nearest, halves away from zero.
// One quotient bit per cycle; depends on rcpsl_pkg.
module rcpsl_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [rcpsl_pkg::PW-1:0] num,
  input  logic [rcpsl_pkg::DW-1:0]        den,
  output logic                            done,
  output logic signed [rcpsl_pkg::PW-1:0] quo
);
  import rcpsl_pkg::*;

  localparam int CW = $clog2(MW + 1);

  logic [MW-1:0] mag_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic          neg_r;
  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] abs_num;
  logic [PW-1:0] biased;
  logic [DW:0]   trial;
  logic          ge;

  always_comb begin
    abs_num = num[PW-1] ? (~num + 1'b1) : num;
    biased  = abs_num + {{(PW-DW){1'b0}}, (den >> 1)};
    trial   = {rem_r, mag_r[MW-1]};
    ge      = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        mag_r  <= biased[MW-1:0];
        rem_r  <= '0;
        den_r  <= den;
        neg_r  <= num[PW-1];
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
        mag_r <= {mag_r[MW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(MW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});

endmodule

>>> rtl/rcpsl_datapath.sv
// Datapath: input registers, per-channel state, calibration registers,
// the shared multiplier and the divider. Depends on rcpsl_pkg and rcpsl_div.
module rcpsl_datapath #(
  parameter int CHANNELS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           channel,
  input  logic [31:0]          capture_count,
  input  logic [15:0]          pulse_us,
  input  logic [31:0]          now_us,
  input  logic [15:0]          dt_us,
  input  logic signed [23:0]   hold_target,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data,
  input  rcpsl_pkg::cmd_t      cmd,
  output rcpsl_pkg::sts_t      sts,
  output logic [1:0]           channel_echo,
  output logic signed [23:0]   deflection_out,
  output logic [1:0]           failsafe,
  output logic                 any_failsafe
);
  import rcpsl_pkg::*;

  localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [1:0]         ch_r;
  logic [31:0]        cnt_r;
  logic [15:0]        w_r;
  logic [31:0]        now_r;
  logic [15:0]        dt_r;
  logic signed [23:0] hold_r;

  logic [31:0]        lcc_r [CHANNELS];
  logic [31:0]        lct_r [CHANNELS];
  logic               co_r  [CHANNELS];
  logic [1:0]         fsm_r [CHANNELS];
  logic signed [23:0] tgt_r [CHANNELS];
  logic signed [23:0] y_r   [CHANNELS];
  logic [15:0]        lo_r  [CHANNELS];
  logic [15:0]        mid_r [CHANNELS];
  logic [15:0]        hi_r  [CHANNELS];
  logic [15:0]        dfl_r [CHANNELS];

  logic signed [PW-1:0] prod_r;
  logic signed [20:0]   defl_r;
  logic signed [PW-1:0] step_r;
  logic [20:0]          lim_r;
  logic [1:0]           och_r;
  logic signed [23:0]   odefl_r;
  logic [1:0]           ofs_r;
  logic                 oany_r;

  logic [CIW-1:0]       idx;
  logic [CIW-1:0]       cfg_idx;
  logic                 in_range;
  logic                 thr;
  logic                 fresh;
  logic [31:0]          age;
  logic [15:0]          x;
  logic signed [16:0]   num;
  logic [15:0]          den;
  logic signed [24:0]   mul_a;
  logic signed [20:0]   mul_b;
  logic [DW-1:0]        div_den;
  logic                 div_done;
  logic signed [PW-1:0] div_quo;
  logic signed [PW-1:0] lim_s;
  logic signed [PW-1:0] step_c;
  logic signed [PW-1:0] y_sum;
  logic                 any_fs;
  logic [15:0]          cmn;
  logic [15:0]          ctr;
  logic [15:0]          cmx;

  always_comb begin
    idx      = CIW'(ch_r);
    cfg_idx  = CIW'(cfg_index);
    in_range = (32'(ch_r) < CHANNELS);
    thr      = (ch_r == THR_CH);
    fresh    = (cnt_r != lcc_r[idx]);
    age      = now_r - lct_r[idx];

    if (w_r < lo_r[idx]) begin
      x = lo_r[idx];
    end else if (w_r > hi_r[idx]) begin
      x = hi_r[idx];
    end else begin
      x = w_r;
    end
    if (thr) begin
      num = $signed({1'b0, x}) - $signed({1'b0, lo_r[idx]});
      den = hi_r[idx] - lo_r[idx];
    end else if (x >= mid_r[idx]) begin
      num = $signed({1'b0, x}) - $signed({1'b0, mid_r[idx]});
      den = hi_r[idx] - mid_r[idx];
    end else begin
      num = $signed({1'b0, x}) - $signed({1'b0, mid_r[idx]});
      den = mid_r[idx] - lo_r[idx];
    end

    unique case (cmd.op)
      OP_DEFL: begin
        mul_a   = {{9{dfl_r[idx][15]}}, dfl_r[idx]};
        mul_b   = thr ? THR_DEFL_MUL : CDEG_RAD_Q32;
        div_den = thr ? THR_DEFL_DIV : SURF_DEFL_DIV;
      end
      OP_MAP: begin
        mul_a   = {{8{num[16]}}, num};
        mul_b   = defl_r;
        div_den = {4'b0, den};
      end
      OP_STEP: begin
        mul_a   = {tgt_r[idx][23], tgt_r[idx]} - {y_r[idx][23], y_r[idx]};
        mul_b   = {5'b0, dt_r};
        div_den = thr ? TAU_THR_US : TAU_SURF_US;
      end
      default: begin
        mul_a   = {9'b0, dt_r};
        mul_b   = thr ? RATE_THR_Q16 : RATE_SURF_Q16;
        div_den = LIM_DIV;
      end
    endcase

    lim_s = {{(PW-21){1'b0}}, lim_r};
    if (step_r > lim_s) begin
      step_c = lim_s;
    end else if (step_r < -lim_s) begin
      step_c = -lim_s;
    end else begin
      step_c = step_r;
    end
    y_sum = {{(PW-24){y_r[idx][23]}}, y_r[idx]} + step_c;

    any_fs = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (fsm_r[i] != FS_LIVE) begin
        any_fs = 1'b1;
      end
    end

    cmn = cfg_data[63:48];
    ctr = cfg_data[47:32];
    cmx = cfg_data[31:16];
  end

  rcpsl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .num   (prod_r),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ch_r   <= channel;
      cnt_r  <= capture_count;
      w_r    <= pulse_us;
      now_r  <= now_us;
      dt_r   <= dt_us;
      hold_r <= hold_target;
    end
    if (cmd.mul_go) begin
      prod_r <= mul_a * mul_b;
    end
    if (div_done) begin
      unique case (cmd.op)
        OP_DEFL: defl_r <= div_quo[20:0];
        OP_STEP: step_r <= div_quo;
        OP_LIM:  lim_r  <= div_quo[20:0];
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      och_r   <= ch_r;
      odefl_r <= in_range ? y_r[idx] : 24'sd0;
      ofs_r   <= in_range ? fsm_r[idx] : FS_LIVE;
      oany_r  <= any_fs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        lcc_r[i] <= '0;
        lct_r[i] <= '0;
        co_r[i]  <= 1'b0;
        fsm_r[i] <= FS_LIVE;
        tgt_r[i] <= '0;
        y_r[i]   <= '0;
      end
    end else begin
      if (cmd.decide && in_range) begin
        if (fresh) begin
          lcc_r[idx] <= cnt_r;
          lct_r[idx] <= now_r;
          co_r[idx]  <= 1'b1;
          fsm_r[idx] <= FS_LIVE;
        end else if (!co_r[idx]) begin
          fsm_r[idx] <= FS_LIVE;
          tgt_r[idx] <= hold_r;
          y_r[idx]   <= hold_r;
        end else if (age > FS_ZERO_US) begin
          fsm_r[idx] <= FS_ZERO;
          tgt_r[idx] <= '0;
        end else if (age > FS_HOLD_US) begin
          fsm_r[idx] <= FS_HOLD;
        end
      end
      if (div_done && cmd.op == OP_MAP) begin
        tgt_r[idx] <= sat24(div_quo);
      end
      if (cmd.commit) begin
        y_r[idx] <= sat24(y_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        lo_r[i]  <= CAL_LO_RST;
        mid_r[i] <= CAL_MID_RST;
        hi_r[i]  <= CAL_HI_RST;
        dfl_r[i] <= defl_reset(i);
      end
    end else if (cfg_wr_en && cfg_index <= NUM_REGS_M1 && 32'(cfg_index) < CHANNELS) begin
      if (cmn < ctr && ctr < cmx) begin
        lo_r[cfg_idx]  <= cmn;
        mid_r[cfg_idx] <= ctr;
        hi_r[cfg_idx]  <= cmx;
      end
      dfl_r[cfg_idx] <= cfg_data[15:0];
    end
  end

  assign sts.fresh     = fresh;
  assign sts.out_range = !in_range;
  assign sts.div_done  = div_done;

  assign channel_echo   = och_r;
  assign deflection_out = odefl_r;
  assign failsafe       = ofs_r;
  assign any_failsafe   = oany_r;

endmodule

>>> rtl/rcpsl_ctrl.sv
// Controller state machine sequencing one item through decide, multiply and divide steps.
// Depends on rcpsl_pkg; drives the datapath through cmd_t and reads sts_t.
module rcpsl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output rcpsl_pkg::cmd_t cmd,
  input  rcpsl_pkg::sts_t sts
);
  import rcpsl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_MUL, S_DSTART, S_DWAIT, S_COMMIT, S_FINISH
  } state_t;

  state_t state_r;
  op_t    op_r;
  logic   out_valid_r;
  logic   can_load;

  assign can_load = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_DEFL;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          priority if (sts.out_range) begin
            state_r <= S_FINISH;
          end else if (sts.fresh) begin
            op_r    <= OP_DEFL;
            state_r <= S_MUL;
          end else begin
            op_r    <= OP_STEP;
            state_r <= S_MUL;
          end
        end
        S_MUL:    state_r <= S_DSTART;
        S_DSTART: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (sts.div_done) begin
            unique case (op_r)
              OP_DEFL: begin
                op_r    <= OP_MAP;
                state_r <= S_MUL;
              end
              OP_MAP: begin
                op_r    <= OP_STEP;
                state_r <= S_MUL;
              end
              OP_STEP: begin
                op_r    <= OP_LIM;
                state_r <= S_MUL;
              end
              default: state_r <= S_COMMIT;
            endcase
          end
        end
        S_COMMIT: state_r <= S_FINISH;
        default: begin
          if (can_load) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_comb begin
    cmd.latch    = (state_r == S_IDLE) && in_tvalid;
    cmd.decide   = (state_r == S_DECIDE);
    cmd.mul_go   = (state_r == S_MUL);
    cmd.div_go   = (state_r == S_DSTART);
    cmd.commit   = (state_r == S_COMMIT);
    cmd.load_out = (state_r == S_FINISH) && can_load;
    cmd.op       = op_r;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  a_accept_decides: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DECIDE))
    else $error("accepted transfer did not enter the decide step");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_DWAIT))
    else $error("divider finished while the controller was not waiting");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_tvalid)
    else $error("result load did not raise out_tvalid");

  a_commit_after_lim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT) |-> (op_r == OP_LIM))
    else $error("commit reached before the rate limit was computed");

endmodule

>>> rtl/rc_pulse_servo_lag_failsafe_unit.sv
// RC pulse normaliser with failsafe and first-order servo lag, top level.
// Joins rcpsl_ctrl and rcpsl_datapath; depends on rcpsl_pkg.
//
// Each input transfer is one control tick for the channel in in_tuser. The
// pulse width is clamped and mapped through the channel calibration, aged
// for failsafe, and a rate-limited first-order lag moves the output towards
// the target. Each input gives exactly one result transfer.
// Calibration registers are written through cfg_wr_en/cfg_index/cfg_data; the user
// must write them only while the block is idle, which the block does not enforce.
// A triplet failing min < trim < max is ignored and the old one kept. A fresh
// capture takes four multiply and divide steps, a stale one two, and an
// out-of-range channel none. One item is processed at a time, and in_tready
// is high only while the controller is idle, so no new item is taken until the last is done.
// The result sits in an output register, so the next item is taken and
// worked on while an earlier result waits for out_tready; a stalled result
// is held and the finished item waits until it has gone.
// Reset (rst_n low, synchronous) clears all channel state and restores the
// default calibration of 1000/1500/2000 us.
module rc_pulse_servo_lag_failsafe_unit #(
  parameter int CHANNELS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // capture_count[31:0], pulse_us[47:32], now_us[79:48], dt_us[95:80], hold_target[119:96]
  input  logic [119:0] in_tdata,
  // channel[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // deflection_out[23:0], failsafe[25:24], any_failsafe[26], zero[31:27]
  output logic [31:0]  out_tdata,
  // channel_echo[1:0]
  output logic [1:0]   out_tuser,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import rcpsl_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic signed [23:0] defl;
  logic [1:0]         fs;
  logic               any_fs;

  rcpsl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rcpsl_datapath #(.CHANNELS(CHANNELS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .channel        (in_tuser),
    .capture_count  (in_tdata[31:0]),
    .pulse_us       (in_tdata[47:32]),
    .now_us         (in_tdata[79:48]),
    .dt_us          (in_tdata[95:80]),
    .hold_target    (in_tdata[119:96]),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .sts            (sts),
    .channel_echo   (out_tuser),
    .deflection_out (defl),
    .failsafe       (fs),
    .any_failsafe   (any_fs)
  );

  assign out_tdata = {5'b0, any_fs, fs, defl};

endmodule

>>> dv/rc_pulse_servo_lag_failsafe_unit_tb.sv
// Self-checking testbench for rc_pulse_servo_lag_failsafe_unit: pulse mapping, failsafe
// ageing and rate-limited lag, checked transfer by transfer against a behavioural predictor.
// Depends on rcpsl_pkg and the RTL of the unit; needs nothing else.
`timescale 1ns / 100ps

module rc_pulse_servo_lag_failsafe_unit_tb;
  import rcpsl_pkg::*;

  typedef struct {
    logic [1:0]         ch;
    logic [31:0]        cnt;
    logic [15:0]        width;
    logic [31:0]        now;
    logic [15:0]        dt;
    logic signed [23:0] hold;
  } tick_t;

  typedef struct {
    logic [1:0]         ch;
    logic signed [23:0] defl;
    logic [1:0]         fs;
    logic               any_fs;
  } servo_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [31:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_wr_en;
  logic [1:0]   cfg_index;
  logic [63:0]  cfg_data;

  rc_pulse_servo_lag_failsafe_unit uut (.*);

  tick_t  ticks_pending[$];
  servo_t servo_expected[$];
  int     errors;
  int     cycles;
  int     in_gap;
  int     out_stall;

  logic [15:0]        cal_lo[4], cal_mid[4], cal_hi[4], cal_defl[4];
  logic [31:0]        seen_cnt[4], seen_time[4];
  logic               seen_once[4];
  logic [1:0]         fs_mode[4];
  logic signed [23:0] tgt[4], lag_y[4];

  logic [31:0] gen_now;
  logic [31:0] gen_cnt[4];

  function automatic longint round_div(longint n, longint d);
    if (d <= 0) return 0;
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic logic signed [23:0] clip24(longint v);
    if (v > 8388607) return 24'sh7FFFFF;
    if (v < -8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [23:0] map_pulse(int c, logic [15:0] w);
    longint lo, mid, hi, x, d;
    lo  = cal_lo[c];
    mid = cal_mid[c];
    hi  = cal_hi[c];
    x   = w;
    d   = longint'($signed(cal_defl[c]));
    if (c == THR_CH) d = round_div(d * 65536, 10000);
    else d = round_div(d * 749613, 65536);
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    if (c == THR_CH) return clip24(round_div((x - lo) * d, hi - lo));
    if (x >= mid) return clip24(round_div((x - mid) * d, hi - mid));
    return clip24(round_div((x - mid) * d, mid - lo));
  endfunction

  function automatic servo_t servo_predict(tick_t t);
    servo_t r;
    int c;
    logic [31:0] age;
    longint tau, lim, stp, dt;
    c   = t.ch;
    dt  = t.dt;
    tau = (c == THR_CH) ? 300000 : 60000;
    age = t.now - seen_time[c];
    if (t.cnt != seen_cnt[c]) begin
      seen_cnt[c]  = t.cnt;
      seen_time[c] = t.now;
      seen_once[c] = 1'b1;
      fs_mode[c]   = FS_LIVE;
      tgt[c]       = map_pulse(c, t.width);
    end else if (!seen_once[c]) begin
      fs_mode[c] = FS_LIVE;
      tgt[c]     = t.hold;
      lag_y[c]   = t.hold;
    end else if (age > FS_ZERO_US) begin
      fs_mode[c] = FS_ZERO;
      tgt[c]     = '0;
    end else if (age > FS_HOLD_US) begin
      fs_mode[c] = FS_HOLD;
    end
    stp = round_div((longint'(tgt[c]) - longint'(lag_y[c])) * dt, tau);
    lim = (dt * ((c == THR_CH) ? 196608 : 343147) + 500000) / 1000000;
    if (stp > lim) stp = lim;
    if (stp < -lim) stp = -lim;
    lag_y[c] = clip24(longint'(lag_y[c]) + stp);
    r.ch     = t.ch;
    r.defl   = lag_y[c];
    r.fs     = fs_mode[c];
    r.any_fs = (fs_mode[0] != FS_LIVE) || (fs_mode[1] != FS_LIVE) ||
               (fs_mode[2] != FS_LIVE) || (fs_mode[3] != FS_LIVE);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  task automatic write_cal(logic [1:0] idx, logic [15:0] mn, logic [15:0] tr,
                           logic [15:0] mx, logic [15:0] d);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= {mn, tr, mx, d};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (mn < tr && tr < mx) begin
      cal_lo[idx]  = mn;
      cal_mid[idx] = tr;
      cal_hi[idx]  = mx;
    end
    cal_defl[idx] = d;
  endtask

  task automatic wait_idle();
    while (ticks_pending.size() != 0 || in_tvalid || servo_expected.size() != 0 ||
           !in_tready || out_tvalid)
      @(negedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic push_tick(logic [1:0] ch, logic [31:0] cnt, logic [15:0] w,
                           logic [31:0] now, logic [15:0] dt, logic [23:0] hold);
    tick_t t;
    t.ch = ch; t.cnt = cnt; t.width = w; t.now = now; t.dt = dt; t.hold = hold;
    ticks_pending.push_back(t);
  endtask

  task automatic push_random_ticks(int n);
    int c, r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      c = $urandom_range(0, 3);
      if (r < 8) begin
        push_tick(2'(c), $urandom, 16'($urandom), $urandom, 16'($urandom), 24'($urandom));
      end else begin
        if (r < 12) gen_now += $urandom_range(100001, 600000);
        else if (r < 15) gen_now += $urandom_range(600001, 2000000);
        else gen_now += $urandom_range(0, 20000);
        if ($urandom_range(0, 99) < 35) gen_cnt[c] += $urandom_range(1, 3);
        push_tick(2'(c), gen_cnt[c],
                  ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(900, 2100)),
                  gen_now,
                  ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5000)),
                  24'($urandom));
      end
    end
  endtask

  task automatic random_cal();
    logic [15:0] mn, tr, mx;
    for (int i = 0; i < 4; i++) begin
      mn = 16'($urandom_range(500, 1400));
      tr = 16'(mn + $urandom_range(1, 600));
      mx = 16'(tr + $urandom_range(1, 600));
      if ($urandom_range(0, 5) == 0) begin
        write_cal(2'(i), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        write_cal(2'(i), mn, tr, mx, 16'($urandom));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      in_gap    <= 0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_gap > 0) begin
        in_gap    <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (ticks_pending.size() != 0) begin
        tick_t t;
        t = ticks_pending.pop_front();
        in_tdata  <= {t.hold, t.dt, t.now, t.width, t.cnt};
        in_tuser  <= t.ch;
        in_tvalid <= 1'b1;
        in_gap    <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall  <= 0;
    end else if (out_stall > 0) begin
      out_stall  <= out_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_stall  <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      tick_t t;
      t.cnt = in_tdata[31:0];
      t.width = in_tdata[47:32];
      t.now = in_tdata[79:48];
      t.dt = in_tdata[95:80];
      t.hold = in_tdata[119:96];
      t.ch = in_tuser;
      servo_expected.push_back(servo_predict(t));
    end
    if (rst_n && out_tvalid && out_tready) begin
      servo_t e;
      if (servo_expected.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        e = servo_expected.pop_front();
        if (out_tuser !== e.ch)
          report_mismatch($sformatf("channel %0d, expected %0d", out_tuser, e.ch));
        if (out_tdata[23:0] !== e.defl)
          report_mismatch($sformatf("ch %0d deflection %0d, expected %0d", e.ch,
                                    $signed(out_tdata[23:0]), e.defl));
        if (out_tdata[25:24] !== e.fs)
          report_mismatch($sformatf("ch %0d failsafe %0d, expected %0d", e.ch,
                                    out_tdata[25:24], e.fs));
        if (out_tdata[26] !== e.any_fs)
          report_mismatch($sformatf("any_failsafe %0b, expected %0b", out_tdata[26], e.any_fs));
        if (out_tdata[31:27] !== 5'd0)
          report_mismatch("padding bits not zero");
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < 4; i++) begin
      cal_lo[i] = CAL_LO_RST;
      cal_mid[i] = CAL_MID_RST;
      cal_hi[i] = CAL_HI_RST;
      cal_defl[i] = defl_reset(i);
      seen_cnt[i] = '0;
      seen_time[i] = '0;
      seen_once[i] = 1'b0;
      fs_mode[i] = FS_LIVE;
      tgt[i] = '0;
      lag_y[i] = '0;
      gen_cnt[i] = $urandom;
    end
    gen_now = $urandom;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Never captured: output follows the hold target at both extremes.
    push_tick(2'd0, 32'd0, 16'd1500, 32'd5, 16'd1000, 24'h7FFFFF);
    push_tick(2'd1, 32'd0, 16'd0, 32'd6, 16'd0, 24'h800000);
    push_tick(2'd2, 32'd0, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 24'h000000);
    push_tick(2'd3, 32'd0, 16'd1500, 32'd7, 16'd1000, 24'hFFFFFF);
    // Fresh captures at clamp extremes and trim.
    push_tick(2'd0, 32'hFFFFFFFF, 16'd0, 32'd1000, 16'hFFFF, 24'h0);
    push_tick(2'd1, 32'd1, 16'hFFFF, 32'd1000, 16'hFFFF, 24'h0);
    push_tick(2'd2, 32'd7, 16'd2000, 32'd1000, 16'hFFFF, 24'h0);
    push_tick(2'd3, 32'd9, 16'd1500, 32'd1000, 16'd20000, 24'h0);
    push_tick(2'd2, 32'd7, 16'd0, 32'd60000, 16'd30000, 24'h0);
    // Stale capture: hold beyond 100 ms, zero beyond 600 ms, then a fresh pulse.
    push_tick(2'd0, 32'hFFFFFFFF, 16'd0, 32'd101001, 16'd1000, 24'h0);
    push_tick(2'd1, 32'd1, 16'd0, 32'd101000, 16'd1000, 24'h0);
    push_tick(2'd0, 32'hFFFFFFFF, 16'd0, 32'd601001, 16'd5000, 24'h0);
    push_tick(2'd0, 32'hFFFFFFFF, 16'd0, 32'd700000, 16'hFFFF, 24'h0);
    push_tick(2'd0, 32'd3, 16'd1200, 32'd700100, 16'd1000, 24'h0);
    // Time wraps past zero.
    push_tick(2'd3, 32'd9, 16'd0, 32'hFFFF0000, 16'd1000, 24'h0);
    push_tick(2'd3, 32'd10, 16'd1800, 32'd50, 16'd2000, 24'h0);
    wait_idle();

    write_cal(2'd0, 16'd1, 16'd2, 16'd65535, 16'h7FFF);
    write_cal(2'd1, 16'd2000, 16'd1500, 16'd1000, 16'h8000);
    write_cal(2'd2, 16'd0, 16'd1, 16'd2, 16'h7FFF);
    write_cal(2'd3, 16'd65533, 16'd65534, 16'd65535, 16'h0000);
    push_tick(2'd0, 32'd100, 16'd65535, gen_now, 16'hFFFF, 24'h0);
    push_tick(2'd1, 32'd100, 16'd65535, gen_now, 16'hFFFF, 24'h0);
    push_tick(2'd2, 32'd100, 16'd65535, gen_now, 16'hFFFF, 24'h0);
    push_tick(2'd3, 32'd100, 16'd0, gen_now, 16'hFFFF, 24'h0);
    push_random_ticks(80);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      random_cal();
      push_random_ticks(80);
      wait_idle();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
